// ----- hw/rtl/tlife_pkg.sv -----
// ============================================================================
// tlife_pkg
// Shared sizes, operation codes and the row memory request bundle for the
// toroidal life automaton.
// ============================================================================
package tlife_pkg;

    // grid bounds and field widths
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 2;

    // operation codes of an input beat
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    // one row of cells
    typedef logic [MAX_COLS-1:0] row_bits_t;

    // request to the row memory
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        row_bits_t        wr_data;
    } mem_req_t;

    // clamp a size register to 1..bound
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] bound);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end
        else if (v > bound) begin
            r = bound;
        end
        else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/toroidal_life_automaton_unit.sv -----
// ============================================================================
// toroidal_life_automaton_unit
// Toroidal B3/S23 life grid with cell write, cell read and generation step,
// run by a sequencer around one row memory and one shared cell unit.
// ============================================================================
// An out-of-grid write or read, or an unused code, goes straight to the response.
// An advance is paced by the single cell unit, which evaluates one cell per cycle
// within a row (paused at each row write-back), and by the memory's single read port.
// Throughput: one beat in flight; the next beat is taken in the cycle its result
// appears, even while that result waits.
// Reset: asynchronous; the grid reads as all dead through per-row valid flags
// (no clearing pass) and both size registers return to 64.
module toroidal_life_automaton_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [tlife_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlife_pkg::SIZE_W-1:0]      cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [tlife_pkg::ROW_W-1:0]       row,
    input  logic [tlife_pkg::COL_W-1:0]       col,
    input  logic                              alive_in,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              alive_out,
    output logic [tlife_pkg::CNT_W-1:0]       live_neighbours,
    output logic                              done_res
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_F0   = 11'b000_0000_0010,
        S_F1   = 11'b000_0000_0100,
        S_F2   = 11'b000_0000_1000,
        S_F3   = 11'b000_0001_0000,
        S_CNT  = 11'b000_0010_0000,
        S_ROW  = 11'b000_0100_0000,
        S_WB   = 11'b000_1000_0000,
        S_NXT  = 11'b001_0000_0000,
        S_WR   = 11'b010_0000_0000,
        S_RESP = 11'b100_0000_0000
    } state_t;

    localparam logic [tlife_pkg::SIZE_W-1:0] ROW_BOUND = tlife_pkg::SIZE_W'(tlife_pkg::MAX_ROWS);
    localparam logic [tlife_pkg::SIZE_W-1:0] COL_BOUND = tlife_pkg::SIZE_W'(tlife_pkg::MAX_COLS);

    state_t                           state_reg, state_next;
    logic [tlife_pkg::SIZE_W-1:0]     row_count_reg, col_count_reg;
    tlife_pkg::op_t                   op_reg, op_next;
    logic [tlife_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [tlife_pkg::COL_W-1:0]      col_reg, col_next;
    logic                             alive_reg, alive_next;
    tlife_pkg::row_bits_t             prev_reg, prev_next;
    tlife_pkg::row_bits_t             cur_reg, cur_next;
    tlife_pkg::row_bits_t             nxt_reg, nxt_next;
    tlife_pkg::row_bits_t             row0_reg, row0_next;
    tlife_pkg::row_bits_t             new_reg, new_next;
    logic [tlife_pkg::ROW_W-1:0]      i_reg, i_next;
    logic [tlife_pkg::COL_W-1:0]      j_reg, j_next;
    logic                             res_alive_reg, res_alive_next;
    logic [tlife_pkg::CNT_W-1:0]      res_cnt_reg, res_cnt_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_alive_reg, out_alive_next;
    logic [tlife_pkg::CNT_W-1:0]      out_cnt_reg, out_cnt_next;

    logic [tlife_pkg::SIZE_W-1:0]     nr, nc;
    logic                             in_inside;
    logic [tlife_pkg::ROW_W-1:0]      r_minus, r_plus, fa0, fa1, fa2;
    logic [tlife_pkg::SIZE_W-1:0]     r_inc, i_plus2;
    logic                             adv;
    tlife_pkg::mem_req_t              mem_req;
    tlife_pkg::row_bits_t             rd_data;
    tlife_pkg::row_bits_t             bit_mask;
    logic                             cu_centre, cu_next_alive;
    logic [tlife_pkg::CNT_W-1:0]      cu_count;
    logic [tlife_pkg::COL_W-1:0]      cu_col;
    logic                             in_accept;

    // effective grid size
    assign nr = tlife_pkg::clamp_size(row_count_reg, ROW_BOUND);
    assign nc = tlife_pkg::clamp_size(col_count_reg, COL_BOUND);

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_BOUND;
            col_count_reg <= COL_BOUND;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tlife_pkg::REG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            else if (cfg_index == tlife_pkg::REG_COL_COUNT)
            begin
                col_count_reg <= cfg_data;
            end
        end
    end

    // row fetch addresses with vertical wrap
    always_comb
    begin
        adv     = (op_reg == tlife_pkg::OP_ADVANCE);
        r_inc   = {1'b0, row_reg} + tlife_pkg::SIZE_W'(1);
        r_minus = (row_reg == '0) ? tlife_pkg::ROW_W'(nr - tlife_pkg::SIZE_W'(1))
                                  : row_reg - tlife_pkg::ROW_W'(1);
        r_plus  = (r_inc == nr) ? '0 : tlife_pkg::ROW_W'(r_inc);
        i_plus2 = {1'b0, i_reg} + tlife_pkg::SIZE_W'(2);
        if (adv)
        begin
            fa0 = tlife_pkg::ROW_W'(nr - tlife_pkg::SIZE_W'(1));
            fa1 = '0;
            fa2 = (nr == tlife_pkg::SIZE_W'(1)) ? '0 : tlife_pkg::ROW_W'(1);
        end
        else
        begin
            fa0 = (op_reg == tlife_pkg::OP_WRITE) ? row_reg : r_minus;
            fa1 = row_reg;
            fa2 = r_plus;
        end
    end

    assign in_accept = in_valid && !in_stall;
    assign in_inside = ({1'b0, row} < nr) && ({1'b0, col} < nc);
    assign bit_mask  = tlife_pkg::row_bits_t'(1) << col_reg;
    assign cu_col    = (state_reg == S_CNT) ? col_reg : j_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        alive_next     = alive_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        row0_next      = row0_reg;
        new_next       = new_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        res_alive_next = res_alive_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_alive_next = out_alive_reg;
        out_cnt_next   = out_cnt_reg;
        mem_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = tlife_pkg::op_t'(operation);
                    row_next       = row;
                    col_next       = col;
                    alive_next     = alive_in;
                    res_alive_next = 1'b0;
                    res_cnt_next   = '0;
                    i_next         = '0;
                    j_next         = '0;
                    if (operation == tlife_pkg::OP_ADVANCE)
                    begin
                        state_next = S_F0;
                    end
                    else if ((operation == tlife_pkg::OP_WRITE
                              || operation == tlife_pkg::OP_READ) && in_inside)
                    begin
                        state_next = S_F0;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_F0:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = fa0;
                state_next      = (op_reg == tlife_pkg::OP_WRITE) ? S_WR : S_F1;
            end
            S_F1:
            begin
                prev_next       = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = fa1;
                state_next      = S_F2;
            end
            S_F2:
            begin
                cur_next        = rd_data;
                new_next        = rd_data;
                row0_next       = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = fa2;
                state_next      = S_F3;
            end
            S_F3:
            begin
                nxt_next   = rd_data;
                state_next = adv ? S_ROW : S_CNT;
            end
            S_CNT:
            begin
                res_alive_next = cu_centre;
                res_cnt_next   = cu_count;
                state_next     = S_RESP;
            end
            S_ROW:
            begin
                new_next[j_reg] = cu_next_alive;
                if ({1'b0, j_reg} == nc - tlife_pkg::SIZE_W'(1))
                begin
                    state_next = S_WB;
                end
                else
                begin
                    j_next = j_reg + tlife_pkg::COL_W'(1);
                end
            end
            S_WB:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = i_reg;
                mem_req.wr_data = new_reg;
                if ({1'b0, i_reg} == nr - tlife_pkg::SIZE_W'(1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = nxt_reg;
                    new_next  = nxt_reg;
                    i_next    = i_reg + tlife_pkg::ROW_W'(1);
                    j_next    = '0;
                    if (i_plus2 >= nr)
                    begin
                        // next row wraps to the saved old top row
                        nxt_next   = row0_reg;
                        state_next = S_ROW;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = tlife_pkg::ROW_W'(i_plus2);
                        state_next      = S_NXT;
                    end
                end
            end
            S_NXT:
            begin
                nxt_next   = rd_data;
                state_next = S_ROW;
            end
            S_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_reg;
                mem_req.wr_data = (rd_data & ~bit_mask)
                                | (alive_reg ? bit_mask : '0);
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_alive_next = res_alive_reg;
                    out_cnt_next   = res_cnt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        alive_reg     <= alive_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        row0_reg      <= row0_next;
        new_reg       <= new_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        res_alive_reg <= res_alive_next;
        res_cnt_reg   <= res_cnt_next;
        out_alive_reg <= out_alive_next;
        out_cnt_reg   <= out_cnt_next;
    end

    // row memory
    tlife_grid_mem u_grid_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // shared cell unit
    tlife_cell_unit u_cell_unit (
        .prev_row   (prev_reg),
        .cur_row    (cur_reg),
        .next_row   (nxt_reg),
        .col        (cu_col),
        .col_size   (nc),
        .centre     (cu_centre),
        .live_count (cu_count),
        .next_alive (cu_next_alive)
    );

    // ports
    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign alive_out       = out_alive_reg;
    assign live_neighbours = out_cnt_reg;
    assign done_res        = 1'b1;

    // column sweep stays inside the grid
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> ({1'b0, j_reg} < nc))
        else $error("column index beyond grid width");

    // row sweep stays inside the grid
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB || state_reg == S_ROW) |-> ({1'b0, i_reg} < nr))
        else $error("row index beyond grid height");

    // never read and write the same row in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("row memory read and write collide");

    // a waiting result is never overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_valid_reg && out_stall)
        |=> (state_reg == S_RESP && out_valid_reg))
        else $error("pending result overwritten");

    // read results only come from a read operation
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CNT) |-> (op_reg == tlife_pkg::OP_READ))
        else $error("neighbour count outside a read");

endmodule

// ----- hw/rtl/tlife_grid_mem.sv -----
// ============================================================================
// tlife_grid_mem
// Row-wide cell memory, one write and one registered read per cycle. Each
// row has a valid flag cleared at reset; a row never written reads as dead.
// ============================================================================
module tlife_grid_mem (
    input  logic                clk,
    input  logic                rst_n,
    input  tlife_pkg::mem_req_t req,
    output tlife_pkg::row_bits_t rd_data
);

    tlife_pkg::row_bits_t             mem [tlife_pkg::MAX_ROWS];
    logic [tlife_pkg::MAX_ROWS-1:0]   row_vld_reg;
    tlife_pkg::row_bits_t             rd_data_reg;
    logic                             rd_vld_reg;

    // row storage and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // row valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
        end
    end

    // unwritten rows read as all dead
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- hw/rtl/tlife_cell_unit.sv -----
// ============================================================================
// tlife_cell_unit
// Shared neighbour counter and B3/S23 rule for one cell, taken from three
// buffered rows with the column wrapped at the grid width.
// ============================================================================
module tlife_cell_unit (
    input  tlife_pkg::row_bits_t            prev_row,
    input  tlife_pkg::row_bits_t            cur_row,
    input  tlife_pkg::row_bits_t            next_row,
    input  logic [tlife_pkg::COL_W-1:0]     col,
    input  logic [tlife_pkg::SIZE_W-1:0]    col_size,
    output logic                            centre,
    output logic [tlife_pkg::CNT_W-1:0]     live_count,
    output logic                            next_alive
);

    logic [tlife_pkg::COL_W-1:0]  col_m;
    logic [tlife_pkg::COL_W-1:0]  col_p;
    logic [tlife_pkg::SIZE_W-1:0] col_inc;

    // wrapped column neighbours
    always_comb
    begin
        col_inc = {1'b0, col} + tlife_pkg::SIZE_W'(1);
        col_m   = (col == '0) ? tlife_pkg::COL_W'(col_size - tlife_pkg::SIZE_W'(1))
                              : col - tlife_pkg::COL_W'(1);
        col_p   = (col_inc == col_size) ? '0 : tlife_pkg::COL_W'(col_inc);
    end

    // eight neighbour sum
    always_comb
    begin
        live_count = tlife_pkg::CNT_W'(prev_row[col_m]) + tlife_pkg::CNT_W'(prev_row[col])
                   + tlife_pkg::CNT_W'(prev_row[col_p]) + tlife_pkg::CNT_W'(cur_row[col_m])
                   + tlife_pkg::CNT_W'(cur_row[col_p])  + tlife_pkg::CNT_W'(next_row[col_m])
                   + tlife_pkg::CNT_W'(next_row[col])   + tlife_pkg::CNT_W'(next_row[col_p]);
    end

    // birth on three, survival on two or three
    assign centre     = cur_row[col];
    assign next_alive = (live_count == tlife_pkg::CNT_W'(3))
                     || (centre && (live_count == tlife_pkg::CNT_W'(2)));

endmodule
